// ===== rtl/vcc_pkg.sv =====
// Shared constants, types and register codes for the Voronoi cell classifier.
// No dependencies; every other file of the block imports this package.
package vcc_pkg;

    // Sizes of the generator store and of the coordinate fields
    localparam int MAX_GEN    = 64;
    localparam int COORD_W    = 16;
    localparam int SLOT_W     = 6;
    localparam int BW_W       = 15;
    localparam int CNT_W      = 7;
    localparam int IDX_W      = $clog2(MAX_GEN);
    localparam int CNT_EFF_W  = $clog2(MAX_GEN + 1);

    // Distance arithmetic: squares, their sum and the bit-serial root
    localparam int PROD_W     = 2 * COORD_W;
    localparam int SQ_W       = PROD_W + 1;
    localparam int ROOT_W     = (SQ_W + 1) / 2;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int REM_W      = ROOT_W + 3;

    // Systolic row: a cell's distance reaches the min-two merge LAG stages later
    localparam int LAG        = 3;
    localparam int CELL_N     = MAX_GEN + LAG;
    localparam int CELL_IDX_W = $clog2(CELL_N);

    // Edge band arithmetic, one bit above the coordinate so 1.0 fits
    localparam int EDGE_W     = COORD_W + 1;
    localparam logic [EDGE_W-1:0] ONE_FIX = EDGE_W'(1) << COORD_W;

    // Configuration port
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;
    localparam int REG_IDX_W  = ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_BORDER_WIDTH = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_GEN_COUNT    = REG_IDX_W'(1);

    // Request opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic [BW_W-1:0]  border_width;
        logic [CNT_W-1:0] generator_count;
    } cfg_t;

    // One stage of the generator row
    typedef struct packed {
        logic               valid;
        logic               op;
        logic [SLOT_W-1:0]  slot;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               in_band;
        logic [COORD_W-1:0] dx;
        logic [COORD_W-1:0] dy;
        logic [PROD_W-1:0]  px;
        logic [PROD_W-1:0]  py;
        logic [SQ_W-1:0]    sq;
        logic               have1;
        logic               have2;
        logic [SQ_W-1:0]    s1;
        logic [SQ_W-1:0]    s2;
        logic [IDX_W-1:0]   best;
    } stage_t;

    // One stage of the dual square-root chain
    typedef struct packed {
        logic              valid;
        logic              query;
        logic              in_band;
        logic              have2;
        logic [IDX_W-1:0]  best;
        logic [RAD_W-1:0]  rad1;
        logic [RAD_W-1:0]  rad2;
        logic [REM_W-1:0]  rem1;
        logic [REM_W-1:0]  rem2;
        logic [ROOT_W-1:0] root1;
        logic [ROOT_W-1:0] root2;
    } root_t;

endpackage

// ===== rtl/vcc_if.sv =====
// Valid/ready channel interfaces for requests into and results out of the classifier.
// Depends on vcc_pkg for field widths.
interface vcc_in_if;
    import vcc_pkg::*;

    logic               valid;
    logic               ready;
    logic               op;
    logic [SLOT_W-1:0]  slot;
    logic [COORD_W-1:0] x_coord;
    logic [COORD_W-1:0] y_coord;

    modport source (output valid, op, slot, x_coord, y_coord, input ready);
    modport sink   (input valid, op, slot, x_coord, y_coord, output ready);
endinterface

interface vcc_out_if;
    import vcc_pkg::*;

    logic              valid;
    logic              ready;
    logic              is_border;
    logic [SLOT_W-1:0] cell_res;

    modport source (output valid, is_border, cell_res, input ready);
    modport sink   (input valid, is_border, cell_res, output ready);
endinterface

// ===== rtl/vcc_cfg.sv =====
// APB-style configuration registers: border width and generator count.
// Depends on vcc_pkg for register codes and cfg_t.
module vcc_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vcc_pkg::ADDR_W-1:0]    paddr,
    input  logic [vcc_pkg::DATA_W-1:0]    pwdata,
    output logic [vcc_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output vcc_pkg::cfg_t                 cfg
);
    import vcc_pkg::*;

    logic [BW_W-1:0]      bw_reg;
    logic [BW_W-1:0]      bw_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    // Register write decode
    always_comb
    begin
        bw_next  = bw_reg;
        cnt_next = cnt_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_BORDER_WIDTH: bw_next  = pwdata[BW_W-1:0];
                REG_GEN_COUNT:    cnt_next = pwdata[CNT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bw_reg  <= '0;
            cnt_reg <= CNT_W'(1);
        end
        else
        begin
            bw_reg  <= bw_next;
            cnt_reg <= cnt_next;
        end
    end

    // Read mux
    always_comb
    begin
        case (reg_idx)
            REG_BORDER_WIDTH: prdata = DATA_W'(bw_reg);
            REG_GEN_COUNT:    prdata = DATA_W'(cnt_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.border_width    = bw_reg;
    assign cfg.generator_count = cnt_reg;

endmodule

// ===== rtl/vcc_cell.sv =====
// One stage of the systolic generator row: holds one generator, starts its distance
// and folds an earlier generator's squared distance into the nearest-two record.
// Depends on vcc_pkg for stage_t and sizes.
module vcc_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            adv,
    input  logic [vcc_pkg::CELL_IDX_W-1:0]  idx,
    input  logic [vcc_pkg::CNT_EFF_W-1:0]   count_eff,
    input  vcc_pkg::stage_t                 stage_in,
    output vcc_pkg::stage_t                 stage_out
);
    import vcc_pkg::*;

    logic [COORD_W-1:0] gx_reg;
    logic [COORD_W-1:0] gy_reg;
    logic               gen_wr;
    logic               merge_en;
    logic               valid_reg;
    stage_t             stage_reg;
    stage_t             stage_next;

    // A load writes this cell's generator as it passes
    assign gen_wr = adv && stage_in.valid && (stage_in.op == OP_LOAD) &&
                    (CELL_IDX_W'(stage_in.slot) == idx);

    always_ff @(posedge clk)
    begin
        if (gen_wr)
        begin
            gx_reg <= stage_in.x;
            gy_reg <= stage_in.y;
        end
    end

    // Squared distance arriving here belongs to generator idx-LAG
    assign merge_en = (32'(idx) >= LAG) && ((32'(idx) - LAG) < 32'(count_eff));

    always_comb
    begin
        stage_next = stage_in;
        // own generator: absolute differences
        stage_next.dx = (gx_reg > stage_in.x) ? gx_reg - stage_in.x : stage_in.x - gx_reg;
        stage_next.dy = (gy_reg > stage_in.y) ? gy_reg - stage_in.y : stage_in.y - gy_reg;
        // previous cell's differences: squares
        stage_next.px = PROD_W'(stage_in.dx) * PROD_W'(stage_in.dx);
        stage_next.py = PROD_W'(stage_in.dy) * PROD_W'(stage_in.dy);
        // two cells back: sum
        stage_next.sq = SQ_W'(stage_in.px) + SQ_W'(stage_in.py);
        // three cells back: nearest-two update, strict compare keeps the lowest slot
        if (merge_en)
        begin
            if (!stage_in.have1 || (stage_in.sq < stage_in.s1))
            begin
                stage_next.s2    = stage_in.s1;
                stage_next.have2 = stage_in.have1;
                stage_next.s1    = stage_in.sq;
                stage_next.have1 = 1'b1;
                stage_next.best  = IDX_W'(idx - CELL_IDX_W'(LAG));
            end
            else if (!stage_in.have2 || (stage_in.sq < stage_in.s2))
            begin
                stage_next.s2    = stage_in.sq;
                stage_next.have2 = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= stage_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            stage_reg <= stage_next;
    end

    always_comb
    begin
        stage_out       = stage_reg;
        stage_out.valid = valid_reg;
    end

endmodule

// ===== rtl/vcc_sqrt_stage.sv =====
// One digit step of two parallel bit-serial integer square roots (floor).
// Depends on vcc_pkg for root_t and sizes.
module vcc_sqrt_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  vcc_pkg::root_t   rin,
    output vcc_pkg::root_t   rout
);
    import vcc_pkg::*;

    logic [REM_W-1:0] rem_sh1;
    logic [REM_W-1:0] rem_sh2;
    logic [REM_W-1:0] trial1;
    logic [REM_W-1:0] trial2;
    logic             valid_reg;
    root_t            root_reg;
    root_t            root_next;

    // Bring down the next two radicand bits and try root*4+1
    assign rem_sh1 = {rin.rem1[REM_W-3:0], rin.rad1[RAD_W-1:RAD_W-2]};
    assign rem_sh2 = {rin.rem2[REM_W-3:0], rin.rad2[RAD_W-1:RAD_W-2]};
    assign trial1  = REM_W'({rin.root1, 2'b01});
    assign trial2  = REM_W'({rin.root2, 2'b01});

    always_comb
    begin
        root_next      = rin;
        root_next.rad1 = rin.rad1 << 2;
        root_next.rad2 = rin.rad2 << 2;
        if (rem_sh1 >= trial1)
        begin
            root_next.rem1  = rem_sh1 - trial1;
            root_next.root1 = {rin.root1[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            root_next.rem1  = rem_sh1;
            root_next.root1 = {rin.root1[ROOT_W-2:0], 1'b0};
        end
        if (rem_sh2 >= trial2)
        begin
            root_next.rem2  = rem_sh2 - trial2;
            root_next.root2 = {rin.root2[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            root_next.rem2  = rem_sh2;
            root_next.root2 = {rin.root2[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= rin.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            root_reg <= root_next;
    end

    always_comb
    begin
        rout       = root_reg;
        rout.valid = valid_reg;
    end

endmodule

// ===== rtl/voronoi_cell_classifier.sv =====
// Voronoi cell classifier: entry stage, systolic generator row, root chain, result register.
// Depends on vcc_pkg, vcc_if, vcc_cfg, vcc_cell and vcc_sqrt_stage.
//
// Usage:
//   in_ch carries requests: op=load writes (x_coord,y_coord) into generator slot,
//   op=query classifies a sample point. Loads give no result; each query gives
//   one result on out_ch: is_border, or the slot of the nearest generator.
//   The APB port holds border_width (0x0) and generator_count (0x4); write them
//   only while no request is in flight. Every slot in use must be loaded before
//   a query reads it.
// Timing:
//   One request is accepted per cycle while the pipeline is not stalled. A query's
//   result passes one entry stage, 67 stages of the generator row (one cell
//   per generator plus three for the multiply/add/compare skew) and 17 digit
//   stages of the square-root chain, then the result register.
//   Loads travel the same row and update their cell in order with queries.
// Reset and stall:
//   Reset clears all pipeline valid bits and the registers (border_width 0,
//   generator_count 1); generator contents are undefined until loaded.
//   When the receiver holds ready low on a waiting result, the whole pipeline
//   freezes and in_ch.ready drops; nothing is dropped or repeated.
module voronoi_cell_classifier (
    input  logic                        clk,
    input  logic                        rst_n,
    vcc_in_if.sink                      in_ch,
    vcc_out_if.source                   out_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [vcc_pkg::ADDR_W-1:0]  paddr,
    input  logic [vcc_pkg::DATA_W-1:0]  pwdata,
    output logic [vcc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import vcc_pkg::*;

    cfg_t                  cfg;
    logic [CNT_EFF_W-1:0]  count_eff;
    logic                  adv;
    logic [EDGE_W-1:0]     bw_ext;
    logic [EDGE_W-1:0]     hi_lim;
    logic [EDGE_W-1:0]     x_ext;
    logic [EDGE_W-1:0]     y_ext;
    logic                  entry_valid_reg;
    stage_t                entry_reg;
    stage_t                entry_next;
    stage_t                row [CELL_N+1];
    root_t                 chain [ROOT_W+1];
    root_t                 last;
    logic [ROOT_W-1:0]     gap;
    logic                  border;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  out_border_reg;
    logic                  out_border_next;
    logic [SLOT_W-1:0]     out_cell_reg;
    logic [SLOT_W-1:0]     out_cell_next;

    vcc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Clamp generator count to 1..MAX_GEN
    always_comb
    begin
        if (cfg.generator_count == '0)
            count_eff = CNT_EFF_W'(1);
        else if (32'(cfg.generator_count) > MAX_GEN)
            count_eff = CNT_EFF_W'(MAX_GEN);
        else
            count_eff = CNT_EFF_W'(cfg.generator_count);
    end

    // Global advance: the pipeline moves unless a result waits unaccepted
    assign adv         = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = adv;

    // Entry stage: edge band test and row state init
    assign bw_ext = EDGE_W'(cfg.border_width);
    assign hi_lim = ONE_FIX - bw_ext;
    assign x_ext  = EDGE_W'(in_ch.x_coord);
    assign y_ext  = EDGE_W'(in_ch.y_coord);

    always_comb
    begin
        entry_next         = '0;
        entry_next.valid   = in_ch.valid;
        entry_next.op      = in_ch.op;
        entry_next.slot    = in_ch.slot;
        entry_next.x       = in_ch.x_coord;
        entry_next.y       = in_ch.y_coord;
        entry_next.in_band = (x_ext <= bw_ext) || (y_ext <= bw_ext) ||
                             (x_ext >= hi_lim) || (y_ext >= hi_lim);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_valid_reg <= 1'b0;
        else if (adv)
            entry_valid_reg <= entry_next.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            entry_reg <= entry_next;
    end

    always_comb
    begin
        row[0]       = entry_reg;
        row[0].valid = entry_valid_reg;
    end

    // Generator row
    for (genvar k = 0; k < CELL_N; k++)
    begin : g_row
        vcc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .idx       (CELL_IDX_W'(k)),
            .count_eff (count_eff),
            .stage_in  (row[k]),
            .stage_out (row[k+1])
        );
    end

    // Root chain input: nearest and second-nearest squared distances
    always_comb
    begin
        chain[0]         = '0;
        chain[0].valid   = row[CELL_N].valid;
        chain[0].query   = (row[CELL_N].op == OP_QUERY);
        chain[0].in_band = row[CELL_N].in_band;
        chain[0].have2   = row[CELL_N].have2;
        chain[0].best    = row[CELL_N].best;
        chain[0].rad1    = RAD_W'(row[CELL_N].s1);
        chain[0].rad2    = RAD_W'(row[CELL_N].s2);
    end

    for (genvar j = 0; j < ROOT_W; j++)
    begin : g_root
        vcc_sqrt_stage u_sqrt (
            .clk   (clk),
            .rst_n (rst_n),
            .adv   (adv),
            .rin   (chain[j]),
            .rout  (chain[j+1])
        );
    end

    assign last = chain[ROOT_W];

    // Border decision on the rounded-down distances
    assign gap    = last.root2 - last.root1;
    assign border = last.in_band || (last.have2 && (32'(gap) <= 32'(cfg.border_width)));

    always_comb
    begin
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_border_next = out_border_reg;
        out_cell_next   = out_cell_reg;
        if (adv)
        begin
            out_valid_next  = last.valid && last.query;
            out_border_next = border;
            out_cell_next   = border ? '0 : SLOT_W'(last.best);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_border_reg <= out_border_next;
        out_cell_reg   <= out_cell_next;
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.is_border = out_border_reg;
    assign out_ch.cell_res  = out_cell_reg;

    // A load leaving the root chain never turns into a result
    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        adv && last.valid && !last.query |=> !out_valid_reg)
        else $error("load produced a result");

    // Every query leaving the row has a nearest generator
    a_query_has_nearest: assert property (@(posedge clk) disable iff (!rst_n)
        row[CELL_N].valid && (row[CELL_N].op == OP_QUERY) |-> row[CELL_N].have1)
        else $error("query left the row without a nearest generator");

    // Second distance never below the nearest after the root chain
    a_root_order: assert property (@(posedge clk) disable iff (!rst_n)
        last.valid && last.query && last.have2 |-> last.root2 >= last.root1)
        else $error("second distance below nearest");

    // A border result carries slot zero
    a_border_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_border_reg |-> out_cell_reg == '0)
        else $error("border result with nonzero slot");

endmodule

// ===== dv/tb_voronoi_cell_classifier.sv =====
// Testbench for voronoi_cell_classifier: a directed table, then random load/query phases;
// each result checked against a typed table value or an in-bench nearest-two-distance predictor.
// Depends on vcc_pkg, vcc_if and the classifier RTL.
module tb_voronoi_cell_classifier;
    import vcc_pkg::*;

    typedef struct packed {
        logic              is_border;
        logic [SLOT_W-1:0] nearest;
    } class_res_t;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    // One line of the directed table: a request, or a register write
    typedef struct packed {
        row_kind_t          kind;
        logic               op;
        logic [SLOT_W-1:0]  slot;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               typed;
        class_res_t         res;
        logic [REG_IDX_W-1:0] reg_sel;
        logic [15:0]        reg_val;
    } dir_row_t;

    localparam int DIR_N     = 25;
    localparam int SETTLE    = 90;
    localparam int LONG_HOLD = 300;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    vcc_in_if  in_ch ();
    vcc_out_if out_ch ();

    voronoi_cell_classifier dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state: generator store and register copies
    logic [COORD_W-1:0] gen_x [MAX_GEN];
    logic [COORD_W-1:0] gen_y [MAX_GEN];
    logic [MAX_GEN-1:0] gen_loaded;
    logic [BW_W-1:0]    bw_cfg;
    logic [CNT_W-1:0]   cnt_cfg;

    class_res_t expected_class_q [$];
    dir_row_t   dir_tab [DIR_N];
    class_res_t seen_res;
    class_res_t want_res;

    int err_cnt;
    bit req_up;
    int snd_idle_max;
    int rcv_idle_max;
    bit long_hold_req;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #1000000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic longint unsigned floor_sqrt(longint unsigned s);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 17; b >= 0; b--)
        begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= s)
                root = trial;
        end
        return root;
    endfunction

    function automatic int in_use_count();
        if (cnt_cfg == 0)
            return 1;
        if (int'(cnt_cfg) > MAX_GEN)
            return MAX_GEN;
        return int'(cnt_cfg);
    endfunction

    // Edge band first, then the gap between nearest and second-nearest distance
    function automatic class_res_t classify_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
        class_res_t      res;
        int              band_hi;
        int              n;
        int              best;
        longint unsigned dx;
        longint unsigned dy;
        longint unsigned d;
        longint unsigned near_d;
        longint unsigned next_d;
        bit              have_near;
        bit              have_next;
        res       = '0;
        band_hi   = 65536 - int'(bw_cfg);
        best      = 0;
        near_d    = 0;
        next_d    = 0;
        have_near = 0;
        have_next = 0;
        if (int'(x) <= int'(bw_cfg) || int'(y) <= int'(bw_cfg) ||
            int'(x) >= band_hi || int'(y) >= band_hi)
        begin
            res.is_border = 1'b1;
            return res;
        end
        n = in_use_count();
        for (int i = 0; i < n; i++)
        begin
            dx = (gen_x[i] > x) ? gen_x[i] - x : x - gen_x[i];
            dy = (gen_y[i] > y) ? gen_y[i] - y : y - gen_y[i];
            d  = floor_sqrt(dx * dx + dy * dy);
            if (!have_near || d < near_d)
            begin
                if (have_near)
                begin
                    next_d    = near_d;
                    have_next = 1;
                end
                near_d    = d;
                best      = i;
                have_near = 1;
            end
            else if (!have_next || d < next_d)
            begin
                next_d    = d;
                have_next = 1;
            end
        end
        if (have_next && next_d - near_d <= longint'(bw_cfg))
            res.is_border = 1'b1;
        else
            res.nearest = best[SLOT_W-1:0];
        return res;
    endfunction

    function automatic logic [COORD_W-1:0] coord_clamp(int v);
        if (v < 0)
            return '0;
        if (v > 65535)
            return '1;
        return v[COORD_W-1:0];
    endfunction

    // Table row builders
    function automatic dir_row_t row_query(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                           logic typed, logic isb, logic [SLOT_W-1:0] nearest);
        dir_row_t r;
        r       = '0;
        r.kind  = ROW_REQ;
        r.op    = OP_QUERY;
        r.slot  = SLOT_W'($urandom());
        r.x     = x;
        r.y     = y;
        r.typed = typed;
        r.res   = '{isb, nearest};
        return r;
    endfunction

    function automatic dir_row_t row_load(logic [SLOT_W-1:0] slot, logic [COORD_W-1:0] x,
                                          logic [COORD_W-1:0] y);
        dir_row_t r;
        r      = '0;
        r.kind = ROW_REQ;
        r.op   = OP_LOAD;
        r.slot = slot;
        r.x    = x;
        r.y    = y;
        return r;
    endfunction

    function automatic dir_row_t row_cfg(logic [REG_IDX_W-1:0] sel, logic [15:0] val);
        dir_row_t r;
        r         = '0;
        r.kind    = ROW_CFG;
        r.reg_sel = sel;
        r.reg_val = val;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    task automatic lower_req();
        if (req_up)
        begin
            in_ch.valid <= 1'b0;
            req_up = 0;
        end
    endtask

    // Offer one request after a random gap; update the predictor when it is taken
    task automatic send_req(logic op, logic [SLOT_W-1:0] slot, logic [COORD_W-1:0] x,
                            logic [COORD_W-1:0] y, bit typed, class_res_t typed_res);
        int gap;
        gap = $urandom_range(0, snd_idle_max);
        if (gap > 0)
        begin
            lower_req();
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.op      <= op;
        in_ch.slot    <= slot;
        in_ch.x_coord <= x;
        in_ch.y_coord <= y;
        req_up = 1;
        do @(posedge clk); while (!in_ch.ready);
        if (op == OP_LOAD)
        begin
            gen_x[slot]      = x;
            gen_y[slot]      = y;
            gen_loaded[slot] = 1'b1;
        end
        else if (typed)
            expected_class_q = {expected_class_q, typed_res};
        else
            expected_class_q = {expected_class_q, classify_point(x, y)};
    endtask

    // Register write: setup then access; psel stays up until released
    task automatic apb_write(logic [REG_IDX_W-1:0] sel, int unsigned val);
        int unsigned wdata;
        int          fw;
        fw    = (sel == REG_BORDER_WIDTH) ? BW_W : CNT_W;
        wdata = ($urandom() << fw) | val;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({sel, 2'b00});
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (sel == REG_BORDER_WIDTH)
            bw_cfg = val[BW_W-1:0];
        else if (sel == REG_GEN_COUNT)
            cnt_cfg = val[CNT_W-1:0];
    endtask

    task automatic apb_release();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Wait for all results, then let trailing loads clear the row
    task automatic drain_settle();
        lower_req();
        while (expected_class_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic pick_idle(bit no_snd);
        snd_idle_max = (no_snd || $urandom_range(0, 2) == 0) ? 0 : 19;
        rcv_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 19;
    endtask

    // One setting of the registers: preload the slots in use, then mixed traffic
    task automatic run_phase(int bw, int cnt, int n_items, bit pause_mid, bit hold);
        int                 eff;
        int                 r;
        int                 i;
        int                 j;
        int                 jit;
        logic [COORD_W-1:0] qx;
        logic [COORD_W-1:0] qy;
        drain_settle();
        apb_write(REG_BORDER_WIDTH, bw);
        apb_write(REG_GEN_COUNT, cnt);
        apb_release();
        eff = in_use_count();
        pick_idle(hold);
        if (hold)
            long_hold_req = 1;
        for (i = 0; i < eff; i++)
            if (!gen_loaded[i] || $urandom_range(0, 3) == 0)
                send_req(OP_LOAD, SLOT_W'(i), COORD_W'($urandom()), COORD_W'($urandom()), 0, '0);
        for (int n = 0; n < n_items; n++)
        begin
            if (!hold && n % 64 == 63)
                pick_idle(0);
            // sender holds back until every result is in
            if (pause_mid && n == n_items / 2)
            begin
                lower_req();
                while (expected_class_q.size() != 0) @(posedge clk);
            end
            r = $urandom_range(0, 99);
            if (r < 15)
            begin
                send_req(OP_LOAD, SLOT_W'($urandom()), COORD_W'($urandom()),
                         COORD_W'($urandom()), 0, '0);
                continue;
            end
            i = $urandom_range(0, eff - 1);
            j = $urandom_range(0, eff - 1);
            if (r < 45)
            begin
                qx = COORD_W'($urandom());
                qy = COORD_W'($urandom());
            end
            else if (r < 75 && eff >= 2)
            begin
                // near the bisector of two generators
                jit = int'(bw_cfg) + 3;
                qx = coord_clamp((int'(gen_x[i]) + int'(gen_x[j])) / 2
                                 + int'($urandom_range(0, 2 * jit)) - jit);
                qy = coord_clamp((int'(gen_y[i]) + int'(gen_y[j])) / 2
                                 + int'($urandom_range(0, 2 * jit)) - jit);
            end
            else
            begin
                jit = 2 * int'(bw_cfg) + 16;
                qx = coord_clamp(int'(gen_x[i]) + int'($urandom_range(0, 2 * jit)) - jit);
                qy = coord_clamp(int'(gen_y[i]) + int'($urandom_range(0, 2 * jit)) - jit);
            end
            send_req(OP_QUERY, SLOT_W'($urandom()), qx, qy, 0, '0);
        end
    endtask

    // Result receiver: random back-pressure, one long hold-off on request
    initial
    begin
        int w;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_req = 0;
                w = 0;
                out_ch.ready <= 1'b1;
            end
            else
            begin
                w = $urandom_range(0, rcv_idle_max);
                if (w > 0)
                begin
                    out_ch.ready <= 1'b0;
                    repeat (w) @(posedge clk);
                end
                out_ch.ready <= 1'b1;
            end
            do @(posedge clk); while (!out_ch.valid);
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            seen_res = '{out_ch.is_border, out_ch.cell_res};
            if (expected_class_q.size() == 0)
                report_mismatch($sformatf("result with none expected: is_border=%0b cell=%0d",
                                          seen_res.is_border, seen_res.nearest));
            else
            begin
                want_res = expected_class_q.pop_front();
                if (seen_res.is_border !== want_res.is_border)
                    report_mismatch($sformatf("is_border got %0b expected %0b",
                                              seen_res.is_border, want_res.is_border));
                if (seen_res.nearest !== want_res.nearest)
                    report_mismatch($sformatf("cell_res got %0d expected %0d",
                                              seen_res.nearest, want_res.nearest));
            end
        end
    end

    // Main sequence
    initial
    begin
        rst_n         <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.op      <= OP_LOAD;
        in_ch.slot    <= '0;
        in_ch.x_coord <= '0;
        in_ch.y_coord <= '0;
        out_ch.ready  <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        err_cnt       = 0;
        req_up        = 0;
        long_hold_req = 0;
        bw_cfg        = '0;
        cnt_cfg       = CNT_W'(1);
        gen_loaded    = '0;
        snd_idle_max  = 19;
        rcv_idle_max  = 19;
        for (int i = 0; i < MAX_GEN; i++)
        begin
            gen_x[i] = '0;
            gen_y[i] = '0;
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset values, edge band, equal distances, count 0, widest band,
        // extreme generator coordinates
        dir_tab = '{
            row_query(16'h0000, 16'h1234, 1'b1, 1'b1, 6'd0),
            row_load(6'd0, 16'h4000, 16'h4000),
            row_query(16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 6'd0),
            row_query(16'h0001, 16'h0001, 1'b1, 1'b0, 6'd0),
            row_query(16'h8000, 16'h0000, 1'b1, 1'b1, 6'd0),
            row_load(6'd1, 16'hC000, 16'h4000),
            row_cfg(REG_GEN_COUNT, 16'd2),
            row_query(16'h8000, 16'h4000, 1'b1, 1'b1, 6'd0),
            row_query(16'h3000, 16'h3000, 1'b1, 1'b0, 6'd0),
            row_query(16'hD000, 16'h5000, 1'b1, 1'b0, 6'd1),
            row_cfg(REG_GEN_COUNT, 16'd0),
            row_query(16'h8000, 16'h4000, 1'b1, 1'b0, 6'd0),
            row_cfg(REG_BORDER_WIDTH, 16'd32767),
            row_query(16'h8000, 16'h8000, 1'b1, 1'b0, 6'd0),
            row_query(16'h7FFF, 16'h8000, 1'b1, 1'b1, 6'd0),
            row_query(16'h8000, 16'h8001, 1'b1, 1'b1, 6'd0),
            row_cfg(REG_BORDER_WIDTH, 16'd1000),
            row_cfg(REG_GEN_COUNT, 16'd2),
            row_query(16'h8100, 16'h4000, 1'b0, 1'b0, 6'd0),
            row_load(6'd0, 16'h0000, 16'h0000),
            row_load(6'd1, 16'hFFFF, 16'hFFFF),
            row_query(16'h8000, 16'h8000, 1'b0, 1'b0, 6'd0),
            row_cfg(REG_BORDER_WIDTH, 16'd0),
            row_query(16'h8000, 16'h8000, 1'b0, 1'b0, 6'd0),
            row_query(16'h7FFF, 16'h7FFF, 1'b0, 1'b0, 6'd0)
        };
        foreach (dir_tab[k])
        begin
            if (dir_tab[k].kind == ROW_CFG)
            begin
                drain_settle();
                apb_write(dir_tab[k].reg_sel, 32'(dir_tab[k].reg_val));
                apb_release();
            end
            else
                send_req(dir_tab[k].op, dir_tab[k].slot, dir_tab[k].x, dir_tab[k].y,
                         dir_tab[k].typed, dir_tab[k].res);
        end

        // Random phases over several register settings
        run_phase(0, 64, 300, 0, 1);
        run_phase(32767, 64, 120, 0, 0);
        run_phase(40, 8, 300, 1, 0);
        run_phase(0, 0, 150, 0, 0);
        run_phase(300, 100, 250, 0, 0);
        run_phase(8, 2, 250, 1, 0);
        run_phase(5, 127, 200, 0, 0);
        repeat (2) run_phase($urandom_range(0, 2000), $urandom_range(1, 64), 200, 0, 0);

        // Wind down
        lower_req();
        while (expected_class_q.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (err_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
